// ----- design/palette_tint_fade_core_macros.svh -----
// Assertion macros for the palette tint and fade core.
`ifndef PALETTE_TINT_FADE_CORE_MACROS_SVH
`define PALETTE_TINT_FADE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define PTF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("palette_tint_fade_core: same-cycle check failed");
// Next-cycle implication, sampled on clk, off during reset.
`define PTF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("palette_tint_fade_core: next-cycle check failed");
`else
`define PTF_ASSERT_NOW(label, ante, cons)
`define PTF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- design/ptf_pkg.sv -----
// Shared constants and types for the palette tint and fade pipeline.
`default_nettype none

package ptf_pkg;

  // Fade factor format
  localparam int FADE_FRAC_BITS = 16;
  localparam int FADE_W         = FADE_FRAC_BITS + 1;
  localparam logic [FADE_W-1:0] FADE_ONE = FADE_W'(1) << FADE_FRAC_BITS;

  // Luma coefficients, Q0.16
  localparam logic [23:0] LUMA_R = 24'd19589;
  localparam logic [23:0] LUMA_G = 24'd38470;
  localparam logic [23:0] LUMA_B = 24'd7471;

  // Ramp constants
  localparam logic [9:0]  WHITE_X4    = 10'd1020;
  localparam logic [16:0] BRIGHT_SPAN = 17'd127;
  localparam logic [7:0]  BRIGHT_DIV  = 8'd127;
  localparam logic [23:0] RAMP_MAX    = 24'hFF0000;
  localparam logic [7:0]  HALF_RESET  = 8'd128;

  // Reciprocals floor(2^32 / n)
  localparam int RECIP_W = 33;
  localparam logic [RECIP_W-1:0] RECIP_BRIGHT = RECIP_W'(64'd4294967296 / 64'd127);
  localparam logic [RECIP_W-1:0] RECIP_RESET  = RECIP_W'(64'd4294967296 / 64'd128);

  // Register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TINT_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TINT_RED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TINT_GREEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TINT_BLUE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_COUNT = 3'd5;

  // Pipeline geometry
  localparam int NCH  = 3;
  localparam int NSTG = 9;

  // Request to the reciprocal unit
  typedef struct packed {
    logic       start;
    logic [7:0] divisor;
  } recip_req_t;

endpackage

`default_nettype wire

// ----- design/ptf_recip.sv -----
// Bit-serial reciprocal unit: floor(2^32 / n) for the dark-ramp divisor.
`default_nettype none

module ptf_recip (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ptf_pkg::recip_req_t          req,
  output logic                         busy,
  output logic [ptf_pkg::RECIP_W-1:0]  recip
);

  localparam int CNT_W = $clog2(ptf_pkg::RECIP_W);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } rcp_state_t;

  rcp_state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [7:0]                   rem_r, rem_nxt;
  logic [7:0]                   div_r, div_nxt;
  logic [ptf_pkg::RECIP_W-1:0]  quo_r, quo_nxt;
  logic [ptf_pkg::RECIP_W-1:0]  recip_r, recip_nxt;
  logic [8:0]                   trial;
  logic                         fits;

  // One restoring step per cycle; dividend is a one followed by zeros
  always_comb begin
    trial     = {rem_r, (cnt_r == '0)};
    fits      = (trial >= {1'b0, div_r});
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    quo_nxt   = quo_r;
    recip_nxt = recip_r;
    case (state_r)
      ST_IDLE: begin
        if (req.start) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
          rem_nxt   = '0;
          div_nxt   = req.divisor;
          quo_nxt   = '0;
        end
      end
      ST_RUN: begin
        rem_nxt = fits ? 8'(trial - {1'b0, div_r}) : trial[7:0];
        quo_nxt = {quo_r[ptf_pkg::RECIP_W-2:0], fits};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ptf_pkg::RECIP_W - 1)) begin
          state_nxt = ST_IDLE;
          recip_nxt = {quo_r[ptf_pkg::RECIP_W-2:0], fits};
        end
        // a new divisor restarts the sweep
        if (req.start) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
          rem_nxt   = '0;
          div_nxt   = req.divisor;
          quo_nxt   = '0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      rem_r   <= '0;
      div_r   <= ptf_pkg::HALF_RESET;
      quo_r   <= '0;
      recip_r <= ptf_pkg::RECIP_RESET;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      div_r   <= div_nxt;
      quo_r   <= quo_nxt;
      recip_r <= recip_nxt;
    end
  end

  assign busy  = (state_r == ST_RUN);
  assign recip = recip_r;

endmodule

`default_nettype wire

// ----- design/palette_tint_fade_core.sv -----
// Palette tint and fade core: top level, nine-stage streaming pipeline.
// Throughput: one palette entry per cycle; out_stall freezes every stage.
// A half_count write runs the reciprocal sweep; input stalls meanwhile.
// Synchronous reset empties the pipeline and loads register defaults.
`default_nettype none
`include "palette_tint_fade_core_macros.svh"

module palette_tint_fade_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_red,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_blue,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ptf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ptf_pkg::FADE_W-1:0]      cfg_data
);

  localparam int NCH   = ptf_pkg::NCH;
  localparam int FW    = ptf_pkg::FADE_W;
  localparam int PF_W  = 24 + FW;
  localparam int WH_W  = FW + 8;
  localparam int SUM_W = PF_W + 1;
  localparam int SHIFT = 16 + ptf_pkg::FADE_FRAC_BITS;

  // ---------------- configuration ----------------
  logic                           mode_r;
  logic [7:0]                     tint_r [NCH];
  logic [FW-1:0]                  fade_r;
  logic [7:0]                     half_r;
  logic                           cfg_we;
  logic [7:0]                     half_wr;
  ptf_pkg::recip_req_t            recip_req;
  logic                           recip_busy;
  logic [ptf_pkg::RECIP_W-1:0]    recip_q;
  logic [FW-1:0]                  fade_eff;
  logic [FW-1:0]                  fade_gap;
  logic [WH_W-1:0]                white;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  // a zero half count divides as one
  assign half_wr   = (cfg_data[7:0] == 8'd0) ? 8'd1 : cfg_data[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      for (int i = 0; i < NCH; i++) tint_r[i] <= '0;
      fade_r <= ptf_pkg::FADE_ONE;
      half_r <= ptf_pkg::HALF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ptf_pkg::CFG_TINT_MODE:  mode_r    <= cfg_data[0];
        ptf_pkg::CFG_TINT_RED:   tint_r[0] <= cfg_data[7:0];
        ptf_pkg::CFG_TINT_GREEN: tint_r[1] <= cfg_data[7:0];
        ptf_pkg::CFG_TINT_BLUE:  tint_r[2] <= cfg_data[7:0];
        ptf_pkg::CFG_FADE:       fade_r    <= cfg_data;
        ptf_pkg::CFG_HALF_COUNT: half_r    <= half_wr;
        default: ;
      endcase
    end
  end

  assign recip_req.start   = cfg_we && (cfg_index == ptf_pkg::CFG_HALF_COUNT);
  assign recip_req.divisor = half_wr;

  ptf_recip u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (recip_req),
    .busy  (recip_busy),
    .recip (recip_q)
  );

  // fade above one acts as one; white term is 255 * (ONE - f)
  assign fade_eff = (fade_r > ptf_pkg::FADE_ONE) ? ptf_pkg::FADE_ONE : fade_r;
  assign fade_gap = ptf_pkg::FADE_ONE - fade_eff;
  assign white    = {fade_gap, 8'd0} - {8'd0, fade_gap};

  // ---------------- flow control ----------------
  logic [ptf_pkg::NSTG-1:0] v_r;
  logic                     adv;

  assign adv       = !(v_r[ptf_pkg::NSTG-1] && out_stall);
  assign in_stall  = !adv || recip_busy ||
                     (cfg_valid && (cfg_index == ptf_pkg::CFG_HALF_COUNT));
  assign out_valid = v_r[ptf_pkg::NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[ptf_pkg::NSTG-2:0], (in_valid && !in_stall)};
    end
  end

  // ---------------- stage registers ----------------
  logic [7:0]                   in_c     [NCH];
  logic [23:0]                  s1_pr_r  [NCH];
  logic [7:0]                   s1_c_r   [NCH];
  logic [23:0]                  s2_y_r;
  logic [7:0]                   s2_c_r   [NCH];
  logic                         s3_dark_r;
  logic [31:0]                  s3_num_r [NCH];
  logic [7:0]                   s3_c_r   [NCH];
  logic [48:0]                  s4_lo_r  [NCH];
  logic [48:0]                  s4_hi_r  [NCH];
  logic [31:0]                  s4_num_r [NCH];
  logic [7:0]                   s4_div_r;
  logic [7:0]                   s4_c_r   [NCH];
  logic [31:0]                  s5_q0_r  [NCH];
  logic [31:0]                  s5_num_r [NCH];
  logic [7:0]                   s5_div_r;
  logic [7:0]                   s5_c_r   [NCH];
  logic [31:0]                  s6_qd_r  [NCH];
  logic [31:0]                  s6_q0_r  [NCH];
  logic [31:0]                  s6_num_r [NCH];
  logic [7:0]                   s6_div_r;
  logic [7:0]                   s6_c_r   [NCH];
  logic [23:0]                  s7_p_r   [NCH];
  logic [PF_W-1:0]              s8_pf_r  [NCH];
  logic [7:0]                   out_c_r  [NCH];

  // combinational stage results
  logic [23:0]                  s1_pr_nxt [NCH];
  logic                         s3_dark_nxt;
  logic [9:0]                   t3        [NCH];
  logic [23:0]                  mul_a;
  logic [9:0]                   mul_b     [NCH];
  logic [16:0]                  t127      [NCH];
  logic [33:0]                  numer     [NCH];
  logic [31:0]                  s3_num_nxt [NCH];
  logic [ptf_pkg::RECIP_W-1:0]  recip_sel;
  logic [7:0]                   s4_div_nxt;
  logic [48:0]                  s4_lo_nxt [NCH];
  logic [48:0]                  s4_hi_nxt [NCH];
  logic [64:0]                  s5_sum    [NCH];
  logic [39:0]                  s6_qd_nxt [NCH];
  logic [31:0]                  rem       [NCH];
  logic [32:0]                  quot      [NCH];
  logic [23:0]                  ramp      [NCH];
  logic [23:0]                  s7_p_nxt  [NCH];
  logic [PF_W-1:0]              s8_pf_nxt [NCH];
  logic [SUM_W-1:0]             fsum      [NCH];
  logic [SUM_W-SHIFT-1:0]       fval      [NCH];
  logic [7:0]                   out_c_nxt [NCH];

  assign in_c[0] = in_red;
  assign in_c[1] = in_green;
  assign in_c[2] = in_blue;

  // stage 1: luma products
  assign s1_pr_nxt[0] = {16'd0, in_c[0]} * ptf_pkg::LUMA_R;
  assign s1_pr_nxt[1] = {16'd0, in_c[1]} * ptf_pkg::LUMA_G;
  assign s1_pr_nxt[2] = {16'd0, in_c[2]} * ptf_pkg::LUMA_B;

  // stage 3: ramp numerator, dark below luma 128.0, bright from there
  assign s3_dark_nxt = !s2_y_r[23];
  assign mul_a       = s3_dark_nxt ? s2_y_r : {1'b0, s2_y_r[22:0]};

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      t3[i]    = {2'b00, tint_r[i]} + {1'b0, tint_r[i], 1'b0};
      mul_b[i] = s3_dark_nxt ? t3[i] : (ptf_pkg::WHITE_X4 - t3[i]);
      t127[i]  = 17'(t3[i]) * ptf_pkg::BRIGHT_SPAN;
      numer[i] = (34'(mul_a) * 34'(mul_b[i])) +
                 (s3_dark_nxt ? 34'd0 : {1'b0, t127[i], 16'd0});
      // divisor carries a factor of four: drop two bits here
      s3_num_nxt[i] = numer[i][33:2];
    end
  end

  // stage 4: reciprocal partial products
  assign recip_sel  = s3_dark_r ? recip_q : ptf_pkg::RECIP_BRIGHT;
  assign s4_div_nxt = s3_dark_r ? half_r : ptf_pkg::BRIGHT_DIV;

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      s4_lo_nxt[i] = 49'(s3_num_r[i][15:0])  * 49'(recip_sel);
      s4_hi_nxt[i] = 49'(s3_num_r[i][31:16]) * 49'(recip_sel);
    end
  end

  // stages 5 to 7: estimate, one-step correction, clamp, mode select
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      s5_sum[i]    = {s4_hi_r[i], 16'd0} + 65'(s4_lo_r[i]);
      // q0 * d never exceeds the numerator, so 32 bits hold it
      s6_qd_nxt[i] = 40'(s5_q0_r[i]) * 40'(s5_div_r);
      rem[i]       = s6_num_r[i] - s6_qd_r[i];
      quot[i]      = {1'b0, s6_q0_r[i]} + 33'(rem[i] >= {24'd0, s6_div_r});
      // any ramp at or past 255.0 fades to 255
      ramp[i]      = (quot[i] >= 33'(ptf_pkg::RAMP_MAX)) ? ptf_pkg::RAMP_MAX
                                                         : quot[i][23:0];
      s7_p_nxt[i]  = mode_r ? ramp[i] : {s6_c_r[i], 16'd0};
    end
  end

  // stages 8 and 9: fade toward white, truncate, saturate
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      s8_pf_nxt[i] = PF_W'(s7_p_r[i]) * PF_W'(fade_eff);
      fsum[i]      = SUM_W'(s8_pf_r[i]) + SUM_W'({white, 16'd0});
      fval[i]      = fsum[i][SUM_W-1:SHIFT];
      out_c_nxt[i] = (fval[i] > (SUM_W-SHIFT)'(255)) ? 8'd255 : fval[i][7:0];
    end
  end

  // payload registers, advance together
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_y_r    <= s1_pr_r[0] + s1_pr_r[1] + s1_pr_r[2];
      s3_dark_r <= s3_dark_nxt;
      s4_div_r  <= s4_div_nxt;
      s5_div_r  <= s4_div_r;
      s6_div_r  <= s5_div_r;
      for (int i = 0; i < NCH; i++) begin
        s1_pr_r[i]  <= s1_pr_nxt[i];
        s1_c_r[i]   <= in_c[i];
        s2_c_r[i]   <= s1_c_r[i];
        s3_num_r[i] <= s3_num_nxt[i];
        s3_c_r[i]   <= s2_c_r[i];
        s4_lo_r[i]  <= s4_lo_nxt[i];
        s4_hi_r[i]  <= s4_hi_nxt[i];
        s4_num_r[i] <= s3_num_r[i];
        s4_c_r[i]   <= s3_c_r[i];
        s5_q0_r[i]  <= s5_sum[i][63:32];
        s5_num_r[i] <= s4_num_r[i];
        s5_c_r[i]   <= s4_c_r[i];
        s6_qd_r[i]  <= s6_qd_nxt[i][31:0];
        s6_q0_r[i]  <= s5_q0_r[i];
        s6_num_r[i] <= s5_num_r[i];
        s6_c_r[i]   <= s5_c_r[i];
        s7_p_r[i]   <= s7_p_nxt[i];
        s8_pf_r[i]  <= s8_pf_nxt[i];
        out_c_r[i]  <= out_c_nxt[i];
      end
    end
  end

  assign out_red   = out_c_r[0];
  assign out_green = out_c_r[1];
  assign out_blue  = out_c_r[2];

  // ---------------- checks ----------------
  `PTF_ASSERT_NOW(a_no_accept_in_sweep, recip_busy, !(in_valid && !in_stall))
  `PTF_ASSERT_NEXT(a_valids_hold_on_stall, !adv, v_r == $past(v_r))
  `PTF_ASSERT_NOW(a_recip_nonzero, $fell(recip_busy), recip_q != '0)

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the palette tint and fade core.
`timescale 1ns / 100ps

module testbench;

  // Index codes past the end of the register list; writes must be dropped
  localparam logic [ptf_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [ptf_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int SETTLE_TICKS = 12;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 215;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_red = 8'd0;
  logic [7:0] in_green = 8'd0;
  logic [7:0] in_blue = 8'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ptf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ptf_pkg::FADE_W-1:0] cfg_data = '0;

  // Shadow copy of the register file
  bit          shd_mode;
  bit [7:0]    shd_tint_r;
  bit [7:0]    shd_tint_g;
  bit [7:0]    shd_tint_b;
  bit [16:0]   shd_fade;
  bit [7:0]    shd_half;

  entry_t pending_display[$];
  entry_t want;
  int err_count = 0;
  int entries_checked = 0;
  int settings_used = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  palette_tint_fade_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Fade a Q.16 ramp point toward white, truncate, saturate
  function automatic logic [7:0] fade_to_white(input bit [63:0] ramp);
    bit [63:0] one;
    bit [63:0] f;
    bit [63:0] sum;
    bit [63:0] v;
    one = 64'(ptf_pkg::FADE_ONE);
    f = (64'(shd_fade) > one) ? one : 64'(shd_fade);
    sum = ramp * f + ((64'd255 * (one - f)) << 16);
    v = sum >> (16 + ptf_pkg::FADE_FRAC_BITS);
    return (v > 64'd255) ? 8'hFF : v[7:0];
  endfunction

  // Two-part ramp toward one tint component, luma in Q8.16
  function automatic bit [63:0] tint_point(input bit [7:0] tint, input bit [63:0] y);
    bit [63:0] t3;
    bit [63:0] n;
    bit [63:0] d;
    t3 = 64'(tint) * 64'd3;
    if (y < (64'd128 << 16)) begin
      n = (shd_half == 8'd0) ? 64'd1 : 64'(shd_half);
      return (y * t3) / (64'd4 * n);
    end
    d = y - (64'd128 << 16);
    return (d * (64'd1020 - t3) + ((t3 * 64'd127) << 16)) / 64'd508;
  endfunction

  // Displayed entry for one original entry under the current registers
  function automatic entry_t display_entry(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    entry_t e;
    bit [63:0] y;
    if (shd_mode) begin
      y = 64'd19589 * 64'(r) + 64'd38470 * 64'(g) + 64'd7471 * 64'(b);
      e.red   = fade_to_white(tint_point(shd_tint_r, y));
      e.green = fade_to_white(tint_point(shd_tint_g, y));
      e.blue  = fade_to_white(tint_point(shd_tint_b, y));
    end else begin
      e.red   = fade_to_white(64'(r) << 16);
      e.green = fade_to_white(64'(g) << 16);
      e.blue  = fade_to_white(64'(b) << 16);
    end
    return e;
  endfunction

  // Receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result checker: each out beat against the oldest pending entry
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_display.size() == 0) begin
        $error("unexpected out beat: red %0d green %0d blue %0d", out_red, out_green, out_blue);
        err_count++;
      end else begin
        want = pending_display.pop_front();
        entries_checked++;
        if (out_red !== want.red) begin
          $error("out_red: expected %0d, got %0d", want.red, out_red);
          err_count++;
        end
        if (out_green !== want.green) begin
          $error("out_green: expected %0d, got %0d", want.green, out_green);
          err_count++;
        end
        if (out_blue !== want.blue) begin
          $error("out_blue: expected %0d, got %0d", want.blue, out_blue);
          err_count++;
        end
      end
    end
  end

  // One register write; valid stays high unless this is the last one
  task automatic write_reg(input logic [ptf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ptf_pkg::FADE_W-1:0] data,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ptf_pkg::CFG_TINT_MODE:  shd_mode   = data[0];
      ptf_pkg::CFG_TINT_RED:   shd_tint_r = data[7:0];
      ptf_pkg::CFG_TINT_GREEN: shd_tint_g = data[7:0];
      ptf_pkg::CFG_TINT_BLUE:  shd_tint_b = data[7:0];
      ptf_pkg::CFG_FADE:       shd_fade   = data[16:0];
      ptf_pkg::CFG_HALF_COUNT: shd_half   = data[7:0];
      default: ;
    endcase
    if (last) begin
      cfg_valid <= 1'b0;
      settings_used++;
    end
  endtask

  // Offer one entry, with optional idle cycles first; log it when accepted
  task automatic send_entry(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_display.push_back(display_entry(r, g, b));
  endtask

  // Drop valid, wait for every pending entry, then let the pipe settle
  task automatic drain_display();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (pending_display.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (pending_display.size() != 0) begin
      $error("%0d entries never came out", pending_display.size());
      err_count++;
    end
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  function automatic logic [7:0] edgy_byte();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Load all six registers at random; upper data bits are junk but for fade
  task automatic pick_setting();
    logic [ptf_pkg::FADE_W-1:0] fade;
    logic [7:0] half;
    case ($urandom_range(5))
      0: fade = 17'd0;
      1: fade = 17'(ptf_pkg::FADE_ONE);
      2: fade = 17'($urandom_range(131071, 65537));
      default: fade = 17'($urandom_range(65536));
    endcase
    case ($urandom_range(7))
      0: half = 8'd0;
      1: half = 8'd1;
      2: half = 8'd255;
      3: half = ptf_pkg::HALF_RESET;
      default: half = 8'($urandom_range(255));
    endcase
    write_reg(ptf_pkg::CFG_TINT_MODE, 17'($urandom), 1'b0);
    write_reg(ptf_pkg::CFG_TINT_RED, {9'($urandom), edgy_byte()}, 1'b0);
    write_reg(ptf_pkg::CFG_TINT_GREEN, {9'($urandom), edgy_byte()}, 1'b0);
    write_reg(ptf_pkg::CFG_TINT_BLUE, {9'($urandom), edgy_byte()}, 1'b0);
    write_reg(ptf_pkg::CFG_FADE, fade, 1'b0);
    write_reg(ptf_pkg::CFG_HALF_COUNT, {9'($urandom), half}, 1'b1);
  endtask

  // Random entries: mostly free, some grays around the luma split, some extremes
  task automatic random_stream(input int count);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] v;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1: begin
          v = 8'($urandom_range(136, 120));
          r = v;
          g = v;
          b = 8'($urandom_range(1)) ? v + 8'($urandom_range(2)) : v;
        end
        2: begin
          r = $urandom_range(1) ? 8'd255 : 8'd0;
          g = $urandom_range(1) ? 8'd255 : 8'd0;
          b = $urandom_range(1) ? 8'd255 : 8'd0;
        end
        default: begin
          r = 8'($urandom);
          g = 8'($urandom);
          b = 8'($urandom);
        end
      endcase
      send_entry(r, g, b);
    end
  endtask

  // Registers straight out of reset: plain mode, no fade
  task automatic test_reset_defaults();
    shd_mode = 1'b0;
    shd_tint_r = 8'd0;
    shd_tint_g = 8'd0;
    shd_tint_b = 8'd0;
    shd_fade = 17'(ptf_pkg::FADE_ONE);
    shd_half = ptf_pkg::HALF_RESET;
    send_entry(8'd0, 8'd0, 8'd0);
    send_entry(8'd255, 8'd255, 8'd255);
    send_entry(8'd255, 8'd0, 8'd170);
    drain_display();
  endtask

  // Plain fade: full fade, factor above one, half fade
  task automatic test_plain_fade();
    write_reg(ptf_pkg::CFG_FADE, 17'd0, 1'b1);
    send_entry(8'd0, 8'd128, 8'd255);
    drain_display();
    write_reg(ptf_pkg::CFG_FADE, 17'h1FFFF, 1'b1);
    send_entry(8'd0, 8'd128, 8'd255);
    drain_display();
    write_reg(ptf_pkg::CFG_FADE, 17'd32768, 1'b1);
    send_entry(8'd0, 8'd0, 8'd0);
    send_entry(8'd255, 8'd255, 8'd255);
    drain_display();
  endtask

  // Tint ramps on both sides of the luma split; mode and tint data masked
  task automatic test_tint_ramps();
    write_reg(ptf_pkg::CFG_TINT_MODE, 17'd3, 1'b0);
    write_reg(ptf_pkg::CFG_TINT_RED, 17'h1FFFF, 1'b0);
    write_reg(ptf_pkg::CFG_TINT_GREEN, 17'h1FF00, 1'b0);
    write_reg(ptf_pkg::CFG_TINT_BLUE, 17'd128, 1'b0);
    write_reg(ptf_pkg::CFG_FADE, 17'(ptf_pkg::FADE_ONE), 1'b1);
    send_entry(8'd128, 8'd128, 8'd128);
    send_entry(8'd129, 8'd129, 8'd129);
    send_entry(8'd0, 8'd0, 8'd0);
    send_entry(8'd255, 8'd255, 8'd255);
    drain_display();
  endtask

  // Dark-ramp divisor: zero, one (overshoot), and the large values
  task automatic test_half_count();
    write_reg(ptf_pkg::CFG_FADE, 17'd40000, 1'b0);
    write_reg(ptf_pkg::CFG_HALF_COUNT, 17'h100, 1'b1);
    send_entry(8'd127, 8'd127, 8'd127);
    drain_display();
    write_reg(ptf_pkg::CFG_HALF_COUNT, 17'd1, 1'b1);
    send_entry(8'd100, 8'd100, 8'd100);
    drain_display();
    write_reg(ptf_pkg::CFG_HALF_COUNT, 17'd129, 1'b1);
    send_entry(8'd60, 8'd90, 8'd30);
    drain_display();
    write_reg(ptf_pkg::CFG_HALF_COUNT, 17'd255, 1'b1);
    send_entry(8'd127, 8'd127, 8'd127);
    drain_display();
  endtask

  // Writes past the register list change nothing
  task automatic test_unused_index();
    write_reg(CFG_SPARE_LO, 17'h1FFFF, 1'b0);
    write_reg(CFG_SPARE_HI, 17'h00055, 1'b0);
    write_reg(ptf_pkg::CFG_TINT_MODE, 17'd2, 1'b1);
    send_entry(8'd17, 8'd200, 8'd99);
    drain_display();
  endtask

  // Random settings and entries across the idle and stall mixes
  task automatic test_random();
    for (int p = 0; p < PHASES; p++) begin
      pick_setting();
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      random_stream(PHASE_ITEMS);
      drain_display();
    end
  endtask

  // Long receiver hold-off while the sender keeps offering beats
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    pick_setting();
    hold_req <= hold_req + 1;
    random_stream(120);
    drain_display();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_plain_fade();
    test_tint_ramps();
    test_half_count();
    test_unused_index();
    test_random();
    test_backpressure();
    $display("testbench: %0d palette entries checked over %0d register settings,",
             entries_checked, settings_used);
    $display("testbench: plain and tint modes, idle/stall mixes and a long output hold-off");
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
